FILE: design/hslfo_pkg.sv
// Shared types, constants, sine table and arithmetic helpers of the harmonic square LFO.
package hslfo_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int MAX_SAMPLES      = 1024;

	localparam int TAB_W   = $clog2(SINE_TABLE_DEPTH);
	localparam int QTR_W   = TAB_W - 2;
	localparam int QDEPTH  = SINE_TABLE_DEPTH / 4;
	localparam int QJ_W    = QTR_W + 1;

	localparam int PHASE_W = 32;
	localparam int INDEX_W = 10;
	localparam int AMP_W   = 16;
	localparam int COUNT_W = 11;
	localparam int SINE_W  = 16;
	localparam int MAG_W   = 15;
	localparam int OUT_W   = 17;
	localparam int CFG_W   = 32;
	localparam int ADDR_W  = 2;

	localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd71582788;
	localparam logic [AMP_W-1:0]   AMP_RST        = 16'd4096;
	localparam logic [COUNT_W-1:0] COUNT_RST      = 11'd64;
	localparam logic [COUNT_W-1:0] DEFAULT_COUNT  = 11'd64;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SINE_FULL   = 64'd32767;

	localparam logic [17:0] ROUND_C  = 18'd245760;
	localparam logic [15:0] ROUND_3  = 16'd49152;
	localparam logic [21:0] RECIP15  = 22'd2236963;
	localparam int          RECIP15_SH = 25;
	localparam logic [17:0] RECIP3   = 18'd174763;
	localparam int          RECIP3_SH  = 19;
	localparam logic [OUT_W-1:0] OUT_MAX_MAG = 17'd65535;
	localparam logic [OUT_W-1:0] OUT_MIN_MAG = 17'd65536;

	typedef enum logic [ADDR_W-1:0] {
		REG_PHASE_STEP   = 2'd0,
		REG_AMPLITUDE    = 2'd1,
		REG_SAMPLE_COUNT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [AMP_W-1:0]   amplitude;
		logic [COUNT_W-1:0] sample_count;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic last;
	} pipe_ctl_t;

	typedef struct packed {
		logic              last_sample;
		logic signed [OUT_W-1:0] third_harmonic;
		logic signed [OUT_W-1:0] composite;
	} out_item_t;

	typedef logic [QDEPTH:0][MAG_W-1:0] qsine_tab_t;

	// restoring long division, used only while the constant table is built
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		int b;
		q = '0;
		r = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic qsine_tab_t build_qsine();
		qsine_tab_t tab;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] t;
		logic [63:0] den;
		logic signed [63:0] acc;
		logic [63:0] v;
		int j;
		int n;
		tab = '0;
		for (j = 0; j <= QDEPTH; j++) begin
			x   = 64'(j) << (30 - QTR_W);
			y   = (x * HALF_PI_Q30) >> 30;
			t   = y;
			acc = $signed(y);
			for (n = 1; n <= 7; n++) begin
				t   = (t * y) >> 30;
				t   = (t * y) >> 30;
				den = 64'((2 * n) * (2 * n + 1));
				t   = long_div(t, den);
				if ((n & 1) == 1) begin
					acc = acc - $signed(t);
				end else begin
					acc = acc + $signed(t);
				end
			end
			if (acc < 0) begin
				acc = 64'sd0;
			end
			if ($unsigned(acc) > Q30_ONE) begin
				acc = $signed(Q30_ONE);
			end
			v = ($unsigned(acc) * SINE_FULL + (Q30_ONE >> 1)) >> 30;
			if (v > SINE_FULL) begin
				v = SINE_FULL;
			end
			tab[j] = v[MAG_W-1:0];
		end
		return tab;
	endfunction

	localparam qsine_tab_t QSINE = build_qsine();

	function automatic logic signed [SINE_W-1:0] sine_at(input logic [TAB_W-1:0] idx);
		logic [1:0]       quad;
		logic [QTR_W-1:0] rem;
		logic [QJ_W-1:0]  j;
		logic [MAG_W-1:0] m;
		quad = idx[TAB_W-1 -: 2];
		rem  = idx[QTR_W-1:0];
		j    = quad[0] ? (QJ_W'(QDEPTH) - {1'b0, rem}) : {1'b0, rem};
		m    = QSINE[j];
		return quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_apply(input logic [OUT_W-1:0] q,
			input logic neg);
		logic [OUT_W-1:0] r;
		if (neg) begin
			r = (q > OUT_MIN_MAG) ? OUT_MIN_MAG : q;
			return $signed(-r);
		end else begin
			r = (q > OUT_MAX_MAG) ? OUT_MAX_MAG : q;
			return $signed(r);
		end
	endfunction

endpackage

FILE: design/hslfo_phase.sv
// Phase stages: index times step, start phase add and last-sample flag.
module hslfo_phase import hslfo_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [PHASE_W-1:0] start_phase,
	input  logic [INDEX_W-1:0] sample_index,
	input  cfg_t               cfg,
	output pipe_ctl_t          ctl,
	output logic [PHASE_W-1:0] phase
);

	logic [PHASE_W+INDEX_W-1:0] mul;
	logic [COUNT_W-1:0]         count_eff;
	logic [COUNT_W-1:0]         index_inc;

	logic [PHASE_W-1:0] prod_s1;
	logic [PHASE_W-1:0] start_s1;
	pipe_ctl_t          ctl_s1;
	logic [PHASE_W-1:0] phase_s2;
	pipe_ctl_t          ctl_s2;

	assign mul = {{INDEX_W{1'b0}}, cfg.phase_step} * {{PHASE_W{1'b0}}, sample_index};

	always_comb begin
		if (cfg.sample_count == '0) begin
			count_eff = DEFAULT_COUNT;
		end else if (int'(cfg.sample_count) > MAX_SAMPLES) begin
			count_eff = COUNT_W'(MAX_SAMPLES);
		end else begin
			count_eff = cfg.sample_count;
		end
	end

	assign index_inc = {1'b0, sample_index} + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.last  <= (index_inc >= count_eff);
			ctl_s2       <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= mul[PHASE_W-1:0];
			start_s1 <= start_phase;
			phase_s2 <= start_s1 + prod_s1;
		end
	end

	assign ctl   = ctl_s2;
	assign phase = phase_s2;

endmodule

FILE: design/hslfo_lookup.sv
// Sine table stage: reads the fundamental, third and fifth harmonic samples.
module hslfo_lookup import hslfo_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  pipe_ctl_t                in_ctl,
	input  logic [PHASE_W-1:0]       phase,
	output pipe_ctl_t                ctl,
	output logic signed [SINE_W-1:0] s1,
	output logic signed [SINE_W-1:0] s3,
	output logic signed [SINE_W-1:0] s5
);

	logic [PHASE_W-1:0] p3;
	logic [PHASE_W-1:0] p5;

	pipe_ctl_t                ctl_s3;
	logic signed [SINE_W-1:0] s1_s3;
	logic signed [SINE_W-1:0] s3_s3;
	logic signed [SINE_W-1:0] s5_s3;

	assign p3 = phase + {phase[PHASE_W-2:0], 1'b0};
	assign p5 = phase + {phase[PHASE_W-3:0], 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_s3 <= sine_at(phase[PHASE_W-1 -: TAB_W]);
			s3_s3 <= sine_at(p3[PHASE_W-1 -: TAB_W]);
			s5_s3 <= sine_at(p5[PHASE_W-1 -: TAB_W]);
		end
	end

	assign ctl = ctl_s3;
	assign s1  = s1_s3;
	assign s3  = s3_s3;
	assign s5  = s5_s3;

endmodule

FILE: design/hslfo_scale.sv
// Scaling stages: harmonic mix, gain, rounded division and saturation.
module hslfo_scale import hslfo_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  pipe_ctl_t                in_ctl,
	input  logic signed [SINE_W-1:0] s1,
	input  logic signed [SINE_W-1:0] s3,
	input  logic signed [SINE_W-1:0] s5,
	input  logic [AMP_W-1:0]         amplitude,
	output pipe_ctl_t                ctl,
	output out_item_t                item
);

	logic signed [20:0] mix;
	logic [35:0]        sumc;
	logic [31:0]        sum3;
	logic [42:0]        mulc;
	logic [35:0]        mul3;

	pipe_ctl_t          ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic [19:0]        magc_s4;
	logic [MAG_W-1:0]   mag3_s4;
	logic               negc_s4, neg3_s4;
	logic [35:0]        prodc_s5;
	logic [30:0]        prod3_s5;
	logic               negc_s5, neg3_s5;
	logic [20:0]        vc_s6;
	logic [16:0]        v3_s6;
	logic               negc_s6, neg3_s6;
	logic [OUT_W-1:0]   qc_s7;
	logic [OUT_W-1:0]   q3_s7;
	logic               negc_s7, neg3_s7;
	out_item_t          item_s8;

	assign mix  = 21'(s1) * 21'sd15 + 21'(s3) * 21'sd5 + 21'(s5) * 21'sd3;
	assign sumc = prodc_s5 + 36'(ROUND_C);
	assign sum3 = {1'b0, prod3_s5} + 32'(ROUND_3);
	assign mulc = {22'b0, vc_s6} * {21'b0, RECIP15};
	assign mul3 = {19'b0, v3_s6} * {18'b0, RECIP3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else if (en) begin
			ctl_s4 <= in_ctl;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magc_s4  <= mix[20] ? 20'(-mix) : mix[19:0];
			negc_s4  <= mix[20];
			mag3_s4  <= s3[SINE_W-1] ? MAG_W'(-s3) : s3[MAG_W-1:0];
			neg3_s4  <= s3[SINE_W-1];

			prodc_s5 <= {16'b0, magc_s4} * {20'b0, amplitude};
			prod3_s5 <= {16'b0, mag3_s4} * {15'b0, amplitude};
			negc_s5  <= negc_s4;
			neg3_s5  <= neg3_s4;

			vc_s6    <= sumc[35:15];
			v3_s6    <= sum3[31:15];
			negc_s6  <= negc_s5;
			neg3_s6  <= neg3_s5;

			qc_s7    <= mulc[RECIP15_SH +: OUT_W];
			q3_s7    <= mul3[RECIP3_SH +: OUT_W];
			negc_s7  <= negc_s6;
			neg3_s7  <= neg3_s6;

			item_s8.composite      <= sat_apply(qc_s7, negc_s7);
			item_s8.third_harmonic <= sat_apply(q3_s7, neg3_s7);
			item_s8.last_sample    <= ctl_s7.last;
		end
	end

	assign ctl  = ctl_s8;
	assign item = item_s8;

endmodule

FILE: design/hslfo_skid.sv
// Two-entry output buffer with a registered ready towards the pipeline.
module hslfo_skid import hslfo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  out_item_t in_item,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      main_v_q;
	logic      skid_v_q;
	out_item_t main_q;
	out_item_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || out_ready) begin
			main_v_q <= skid_v_q || in_valid;
			skid_v_q <= 1'b0;
		end else if (in_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) begin
			main_q <= skid_v_q ? skid_q : in_item;
		end else if (in_valid && !skid_v_q) begin
			skid_q <= in_item;
		end
	end

	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_item  = main_q;

endmodule

FILE: design/harmonic_square_lfo_sample_unit.sv
// Top level of the harmonic square LFO sample generator.
//
//  channel   | ports                         | transaction
//  ----------+-------------------------------+------------------------------------------
//  s_ (in)   | s_tvalid s_tready s_tdata     | start phase and sample index
//  m_ (out)  | m_tvalid m_tready m_tdata     | composite, third harmonic, tlast = last
//  cfg_      | cfg_we cfg_addr cfg_wdata     | register write, no read-back
//
//  One transaction per cycle while the output buffer has room; the eight-stage pipeline
//  makes one sine-table read per harmonic in the lookup stage.
//  Reset loads the register defaults; the sine table is constant, so no clearing pass.
//  A stalled output holds in a two-entry buffer whose ready is registered; the whole
//  pipeline holds while that buffer is full.
module harmonic_square_lfo_sample_unit import hslfo_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // start_phase[31:0], sample_index[41:32], zero pad
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,   // composite[16:0], third_harmonic[33:17], zero pad
	output logic              m_tlast,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	cfg_t                     cfg_q;
	logic                     en;
	pipe_ctl_t                ctl_ph, ctl_lk, ctl_sc;
	logic [PHASE_W-1:0]       phase;
	logic signed [SINE_W-1:0] s1, s3, s5;
	out_item_t                item_sc;
	out_item_t                item_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step   <= PHASE_STEP_RST;
			cfg_q.amplitude    <= AMP_RST;
			cfg_q.sample_count <= COUNT_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_PHASE_STEP:   cfg_q.phase_step   <= cfg_wdata[PHASE_W-1:0];
				REG_AMPLITUDE:    cfg_q.amplitude    <= cfg_wdata[AMP_W-1:0];
				REG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = en;

	hslfo_phase u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_tvalid),
		.start_phase  (s_tdata[PHASE_W-1:0]),
		.sample_index (s_tdata[PHASE_W +: INDEX_W]),
		.cfg          (cfg_q),
		.ctl          (ctl_ph),
		.phase        (phase)
	);

	hslfo_lookup u_lookup (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_ctl (ctl_ph),
		.phase  (phase),
		.ctl    (ctl_lk),
		.s1     (s1),
		.s3     (s3),
		.s5     (s5)
	);

	hslfo_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_ctl    (ctl_lk),
		.s1        (s1),
		.s3        (s3),
		.s5        (s5),
		.amplitude (cfg_q.amplitude),
		.ctl       (ctl_sc),
		.item      (item_sc)
	);

	hslfo_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ctl_sc.valid),
		.in_item   (item_sc),
		.in_ready  (en),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (item_out)
	);

	assign m_tdata = {6'b0, item_out.third_harmonic, item_out.composite};
	assign m_tlast = item_out.last_sample;

	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_sc.valid && !en |=> ctl_sc.valid)
		else $error("pipeline dropped an item while the output buffer was full");

	a_third_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (item_out.third_harmonic >= -17'sd21845 &&
			item_out.third_harmonic <= 17'sd21845))
		else $error("third harmonic beyond its scaled range");

endmodule
